// File: design/set_assoc_lru_cache_lookup_core_macros.svh
// assertion helpers shared by the cache lookup modules
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SALC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define SALC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/salc_pkg.sv
`default_nettype none

package salc_pkg;

  // cache geometry
  localparam int unsigned WAYS        = 4;
  localparam int unsigned SET_COUNT   = 64;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned ADDR_BITS   = 32;

  // port widths fixed by the interface
  localparam int unsigned IN_ADDR_BITS  = 32;
  localparam int unsigned OUT_WAY_BITS  = 2;

  // derived address split
  localparam int unsigned OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_BITS    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned TAG_LSB     = OFFSET_BITS + $clog2(SET_COUNT);
  localparam int unsigned TAG_BITS    = ADDR_BITS - TAG_LSB;

  // way index and age rank widths
  localparam int unsigned WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(WAYS - 1);
  // rank of an invalid way, older than any valid one
  localparam logic [RANK_BITS:0] RANK_INVALID = (RANK_BITS + 1)'(WAYS);

  // one tag-store row holds tag and rank of every way of a set
  localparam int unsigned ENTRY_BITS = TAG_BITS + RANK_BITS;
  localparam int unsigned ROW_BITS   = WAYS * ENTRY_BITS;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch address and read the set row
    logic update;   // write back the row and load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: design/set_assoc_lru_cache_lookup_core.sv
`default_nettype none

// Set-associative cache lookup with true LRU replacement (4 ways, 64 sets,
// 16-byte blocks, 32-bit addresses). Each transaction carries one byte address
// and returns hit and the way that hit or was filled; the used way becomes
// youngest. On capture the set's row of tags and age ranks is read from the
// row RAM; in the lookup state all ways are compared in parallel and the
// updated row is written back. No new address is taken until lookup ends;
// lookup waits while a stalled result fills the result register, which lets
// the next address in while that result waits on out_stall_i. Valid flags
// are flip-flops cleared by reset, so no clearing pass is needed after reset.
module set_assoc_lru_cache_lookup_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [salc_pkg::IN_ADDR_BITS-1:0]    byte_address_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      hit_o,
  output logic      [salc_pkg::OUT_WAY_BITS-1:0]    way_used_o
);

  salc_pkg::ctrl_cmd_t cmd;

  // transaction sequencing
  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // tag compare, replacement and age update
  salc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .byte_address_i (byte_address_i),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o)
  );

endmodule

`default_nettype wire

// File: design/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/salc_ctrl.sv
`default_nettype none
`include "set_assoc_lru_cache_lookup_core_macros.svh"

module salc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output salc_pkg::ctrl_cmd_t    cmd_o
);

  salc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // state and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      salc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        // finish only when the result register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = salc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = salc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `SALC_ASSERT_NXT(a_capture_to_lookup, cmd_o.capture, state_q == salc_pkg::ST_LOOKUP, "capture did not enter lookup")
  `SALC_ASSERT_IMP(a_no_result_overwrite, cmd_o.update, !out_valid_o || !out_stall_i, "pending result overwritten")
  `SALC_ASSERT_NXT(a_update_presents, cmd_o.update, out_valid_o && (state_q == salc_pkg::ST_IDLE), "result not presented after update")

endmodule

`default_nettype wire

// File: design/salc_dp.sv
`default_nettype none
`include "set_assoc_lru_cache_lookup_core_macros.svh"

module salc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  salc_pkg::ctrl_cmd_t                       cmd_i,
  input  wire logic [salc_pkg::IN_ADDR_BITS-1:0]    byte_address_i,
  output logic                                      hit_o,
  output logic      [salc_pkg::OUT_WAY_BITS-1:0]    way_used_o
);

  localparam int unsigned W   = salc_pkg::WAYS;
  localparam int unsigned TB  = salc_pkg::TAG_BITS;
  localparam int unsigned RB  = salc_pkg::RANK_BITS;
  localparam int unsigned EB  = salc_pkg::ENTRY_BITS;
  localparam int unsigned WB  = salc_pkg::WAY_BITS;
  localparam int unsigned SB  = salc_pkg::SET_BITS;

  // address fields of the current transaction
  logic [SB-1:0] set_q;
  logic [TB-1:0] tag_q;
  logic [SB-1:0] set_in;
  logic [TB-1:0] tag_in;

  // per-way valid flags, cleared by reset
  logic [salc_pkg::SET_COUNT-1:0][W-1:0] valid_q;

  // row storage
  logic [salc_pkg::ROW_BITS-1:0] row_rd;
  logic [salc_pkg::ROW_BITS-1:0] row_wr;
  logic [SB-1:0]                 ram_raddr;

  // lookup results
  logic [W-1:0]          valid_row;
  logic [W-1:0][TB-1:0]  tag_rd;
  logic [W-1:0][RB-1:0]  rank_rd;
  logic [W-1:0]          match;
  logic                  hit;
  logic                  have_inv;
  logic [WB-1:0]         hit_way;
  logic [WB-1:0]         inv_way;
  logic [WB-1:0]         old_way;
  logic [WB-1:0]         way;
  logic [RB:0]           old_rank;
  logic [W-1:0][RB-1:0]  rank_new;
  logic [W-1:0][TB-1:0]  tag_new;

  // address split, bits above the address width are dropped
  assign set_in = SB'(byte_address_i[salc_pkg::TAG_LSB-1:salc_pkg::OFFSET_BITS]);
  assign tag_in = byte_address_i[salc_pkg::ADDR_BITS-1:salc_pkg::TAG_LSB];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  assign ram_raddr = cmd_i.capture ? set_in : set_q;

  salc_ram #(
    .WIDTH (salc_pkg::ROW_BITS),
    .DEPTH (salc_pkg::SET_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.capture),
    .raddr_i (ram_raddr),
    .rdata_o (row_rd)
  );

  // unpack the row and compare tags in parallel
  always_comb begin
    valid_row = valid_q[set_q];
    for (int w = 0; w < W; w++) begin
      tag_rd[w]  = row_rd[w*EB +: TB];
      rank_rd[w] = row_rd[w*EB + TB +: RB];
      match[w]   = valid_row[w] && (tag_rd[w] == tag_q);
    end
  end

  // way selection: hit, else lowest invalid, else oldest with ties low
  always_comb begin
    hit      = |match;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    old_way  = '0;
    for (int w = W - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WB'(w);
      end
      if (!valid_row[w]) begin
        inv_way  = WB'(w);
        have_inv = 1'b1;
      end
    end
    for (int w = 1; w < W; w++) begin
      if (rank_rd[w] > rank_rd[old_way]) begin
        old_way = WB'(w);
      end
    end
    if (hit) begin
      way      = hit_way;
      old_rank = {1'b0, rank_rd[hit_way]};
    end else if (have_inv) begin
      way      = inv_way;
      old_rank = salc_pkg::RANK_INVALID;
    end else begin
      way      = old_way;
      old_rank = {1'b0, rank_rd[old_way]};
    end
  end

  // age update and new row contents
  always_comb begin
    for (int w = 0; w < W; w++) begin
      rank_new[w] = rank_rd[w];
      tag_new[w]  = tag_rd[w];
      if (WB'(w) == way) begin
        rank_new[w] = '0;
        if (!hit) begin
          tag_new[w] = tag_q;
        end
      end else if (valid_row[w] && ({1'b0, rank_rd[w]} < old_rank)
                   && (rank_rd[w] != salc_pkg::RANK_MAX)) begin
        rank_new[w] = rank_rd[w] + 1'b1;
      end
      row_wr[w*EB +: TB]      = tag_new[w];
      row_wr[w*EB + TB +: RB] = rank_new[w];
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update) begin
      valid_q[set_q][way] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o      <= hit;
      way_used_o <= salc_pkg::OUT_WAY_BITS'(way);
    end
  end

  `SALC_ASSERT_IMP(a_single_match, cmd_i.update, $onehot0(match), "several ways hold the same tag")
  `SALC_ASSERT_NXT(a_used_way_valid, cmd_i.update, valid_q[$past(set_q)][$past(way)], "used way not marked valid")
  `SALC_ASSERT_IMP(a_fill_prefers_invalid, cmd_i.update && !hit && have_inv, !valid_row[way], "fill evicted a valid way while an invalid one was free")

endmodule

`default_nettype wire
